@@ hdl/mtft_pkg.sv @@
// Shared constants, types and register codes for the move-to-front key order.
package mtft_pkg;

	localparam int MAX_COLUMNS = 32;
	localparam int KEY_W       = 5;
	localparam int IDX_W       = $clog2(MAX_COLUMNS);
	localparam int CMP_W       = (IDX_W > KEY_W) ? IDX_W : KEY_W;
	localparam int ACT_W       = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;
	localparam int CNT_REG_W   = 6;
	localparam int CFG_DATA_W  = 6;

	typedef enum logic [0:0] {
		REG_ACTIVE_COLUMNS     = 1'b0,
		REG_DEFAULT_DESCENDING = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_SELECT = 1'b0,
		OP_REINIT = 1'b1
	} op_t;

	// Broadcast to every cell for one item.
	typedef struct packed {
		logic             select;
		logic             reinit;
		logic             deflt;
		logic [KEY_W-1:0] column;
	} ctl_t;

endpackage

@@ hdl/move_to_front_order_with_toggle_top.sv @@
// Top level: row of order cells, configuration registers and registered result.
// The result of an accepted item is held in the output register from the next cycle.
// Throughput: one item per cycle unless the output stalls; the cell row searches
// combinationally along a hit chain through all MAX_COLUMNS cells, then shifts.
// Reset: order is identity, all flags clear, active_columns 32, default flag 0,
// output register empty.
module move_to_front_order_with_toggle_top
	import mtft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [4:0] column, [7:5] zero
	input  logic [0:0]            s_tuser,  // [0] operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,  // [0] found, [5:1] old_position,
	                                        // [6] key_descending, [11:7] lead_column
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CNT_REG_W-1:0] active_q;
	logic                 deflt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_REG_W'(32);
			deflt_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_COLUMNS:     active_q <= cfg_data[CNT_REG_W-1:0];
				REG_DEFAULT_DESCENDING: deflt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic accept;
	ctl_t ctl;

	assign s_tready   = !m_tvalid || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign ctl.select = accept && (op_t'(s_tuser[0]) == OP_SELECT);
	assign ctl.reinit = accept && (op_t'(s_tuser[0]) == OP_REINIT);
	assign ctl.deflt  = deflt_q;
	assign ctl.column = s_tdata[KEY_W-1:0];

	logic [IDX_W-1:0]       key  [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] flag;
	logic [MAX_COLUMNS-1:0] hit;
	logic [MAX_COLUMNS:0]   tail;
	logic                   hit_flag;

	assign tail[MAX_COLUMNS] = 1'b0;
	assign hit_flag          = |(hit & flag);

	for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
		logic [IDX_W-1:0] lkey;
		logic             lflag;
		if (i == 0) begin : g_front
			assign lkey  = ctl.column[IDX_W-1:0];
			assign lflag = hit_flag;
		end else begin : g_rest
			assign lkey  = key[i-1];
			assign lflag = flag[i-1];
		end
		mtft_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.idx      (IDX_W'(i)),
			.first    (i == 0),
			.active   (ACT_W'(i) < ACT_W'(active_q)),
			.left_key (lkey),
			.left_flag(lflag),
			.tail_in  (tail[i+1]),
			.key      (key[i]),
			.flag     (flag[i]),
			.hit      (hit[i]),
			.tail_out (tail[i])
		);
	end

	// one-hot hit to position
	logic [IDX_W-1:0] pos;
	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			if (hit[i]) pos = pos | IDX_W'(i);
		end
	end

	logic             found;
	logic             res_flag;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] key0_w;
	logic [KEY_W-1:0] lead;

	assign found    = tail[0];
	assign res_flag = found && (hit[0] ? ~hit_flag : hit_flag);
	assign pos_w    = CMP_W'(pos);
	assign key0_w   = CMP_W'(key[0]);
	assign lead     = ctl.reinit ? '0 : (found ? ctl.column : key0_w[KEY_W-1:0]);

	logic             m_tvalid_q;
	logic             found_q;
	logic [KEY_W-1:0] pos_q;
	logic             flag_q;
	logic [KEY_W-1:0] lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q <= found;
			pos_q   <= pos_w[KEY_W-1:0];
			flag_q  <= res_flag;
			lead_q  <= lead;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, lead_q, flag_q, pos_q, found_q};

`ifndef NO_ASSERTIONS
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one cell hit");

	a_hit_to_front: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.select && found |=> CMP_W'(key[0]) == CMP_W'($past(ctl.column)))
		else $error("selected key not at front");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.select && !found |=> m_tvalid && pos_q == '0 && !flag_q && !found_q)
		else $error("miss result not cleared");

	a_reinit_front: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.reinit |=> key[0] == '0 && lead_q == '0 && flag[0] == $past(deflt_q))
		else $error("reinit did not restore front");
`endif

endmodule

@@ hdl/mtft_cell.sv @@
// One slot of the order: holds a key and its direction flag, shifts from its left neighbor.
module mtft_cell
	import mtft_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic             first,
	input  logic             active,
	input  logic [IDX_W-1:0] left_key,
	input  logic             left_flag,
	input  logic             tail_in,
	output logic [IDX_W-1:0] key,
	output logic             flag,
	output logic             hit,
	output logic             tail_out
);

	logic [IDX_W-1:0] key_q;
	logic             flag_q;
	logic             load;
	logic             toggle;

	assign hit      = ctl.select && active && (CMP_W'(key_q) == CMP_W'(ctl.column));
	assign tail_out = hit || tail_in;
	// the hit cell and all before it take their left neighbor; the front cell toggles on hit
	assign load     = tail_out && !(first && hit);
	assign toggle   = first && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= idx;
			flag_q <= 1'b0;
		end else if (ctl.reinit) begin
			key_q  <= idx;
			flag_q <= ctl.deflt;
		end else if (load) begin
			key_q  <= left_key;
			flag_q <= left_flag;
		end else if (toggle) begin
			flag_q <= ~flag_q;
		end
	end

	assign key  = key_q;
	assign flag = flag_q;

endmodule
